// ===== src/slc_pkg.sv =====
`default_nettype none

package slc_pkg;

    // Field widths of the command and response words.
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 2;

    // Default list capacity.
    localparam int DEFAULT_DEPTH = 64;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    // Command codes.
    localparam t_op OP_APPEND  = 3'd0;
    localparam t_op OP_DEL_MIN = 3'd1;
    localparam t_op OP_DEL_VAL = 3'd2;
    localparam t_op OP_DEDUP   = 3'd3;
    localparam t_op OP_READ    = 3'd4;
    localparam t_op OP_CLEAR   = 3'd5;

    // Status codes.
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;
    localparam t_status STATUS_RANGE = 2'd3;

endpackage

`default_nettype wire

// ===== src/slc_if.sv =====
`default_nettype none

// Command channel: one word per list command.
interface slc_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [slc_pkg::OP_W-1:0]          op;
    logic signed [slc_pkg::VALUE_W-1:0] value;
    logic [slc_pkg::POS_W-1:0]         position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

// Response channel: one word per command.
interface slc_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [slc_pkg::VALUE_W-1:0]  result_value;
    logic [slc_pkg::LEN_W-1:0]           list_length;
    logic [slc_pkg::STATUS_W-1:0]        status;

    modport source (output valid, output result_value, output list_length, output status,
                    input ready);
    modport sink   (input valid, input result_value, input list_length, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== src/slc_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module slc_ram #(
    parameter int WIDTH = slc_pkg::VALUE_W,
    parameter int DEPTH = slc_pkg::DEFAULT_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/sequential_list_compactor_core.sv =====
// Append, clear, unused codes and errors go from acceptance straight to the done state; read at goes
// through the read wait state; delete value and dedup walk the list in the scan state (dedup on an
// empty list goes straight to done); delete min walks it, then the fix-read and fix-write states.
// Throughput: one command at a time, and the RAM read port walks the list one entry per cycle.
// Reset (synchronous, active low) empties the list and clears the sequencer and the
// response valid; the entry RAM is not cleared and only entries below the length are read.
`default_nettype none

module sequential_list_compactor_core #(
    parameter int DEPTH = slc_pkg::DEFAULT_DEPTH
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    slc_cmd_if.sink    i_cmd,
    slc_rsp_if.source  o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = slc_pkg::VALUE_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_FIX_RD  = 3'd2;
    localparam logic [2:0] ST_FIX_WR  = 3'd3;
    localparam logic [2:0] ST_RD_WAIT = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    // Control registers.
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_dv, n_dv;
    logic          r_out_valid, n_out_valid;

    // Working registers.
    slc_pkg::t_op     r_op, n_op;
    logic [CW-1:0]    r_i, n_i;
    logic [AW-1:0]    r_di, n_di;
    logic [CW-1:0]    r_k, n_k;
    logic [VW-1:0]    r_cmp, n_cmp;
    logic [VW-1:0]    r_min, n_min;
    logic [AW-1:0]    r_idx, n_idx;
    logic [VW-1:0]    r_res_value, n_res_value;
    slc_pkg::t_status r_res_status, n_res_status;
    logic [VW-1:0]    r_out_value, n_out_value;
    logic [CW-1:0]    r_out_len, n_out_len;
    slc_pkg::t_status r_out_status, n_out_status;

    // RAM port signals.
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [VW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [VW-1:0] w_rdata;

    // Shared compare unit.
    logic          w_lt;
    logic          w_eq;
    logic          w_accept;
    logic [CW-1:0] w_last;

    slc_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_lt     = $signed(w_rdata) < $signed(r_min);
    assign w_eq     = (w_rdata == r_cmp);
    assign w_accept = i_cmd.valid && i_cmd.ready;
    assign w_last   = r_count - CW'(1);

    assign i_cmd.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.list_length  = slc_pkg::LEN_W'(r_out_len);
    assign o_rsp.status       = r_out_status;

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_dv         = 1'b0;
        n_out_valid  = r_out_valid;
        n_op         = r_op;
        n_i          = r_i;
        n_di         = r_di;
        n_k          = r_k;
        n_cmp        = r_cmp;
        n_min        = r_min;
        n_idx        = r_idx;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_value  = r_out_value;
        n_out_len    = r_out_len;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        w_waddr      = r_k[AW-1:0];
        w_wdata      = w_rdata;
        w_raddr      = r_i[AW-1:0];

        // The waiting response word leaves when the sink takes it.
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_op         = i_cmd.op;
                    n_cmp        = i_cmd.value;
                    n_res_value  = '0;
                    n_res_status = slc_pkg::STATUS_OK;
                    n_i          = '0;
                    n_k          = '0;
                    n_state      = ST_DONE;
                    case (i_cmd.op)
                        slc_pkg::OP_APPEND: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_res_status = slc_pkg::STATUS_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_count[AW-1:0];
                                w_wdata = i_cmd.value;
                                n_count = r_count + CW'(1);
                            end
                        end
                        slc_pkg::OP_DEL_MIN: begin
                            if (r_count == '0) begin
                                n_res_status = slc_pkg::STATUS_EMPTY;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        slc_pkg::OP_DEL_VAL: begin
                            n_state = ST_SCAN;
                        end
                        slc_pkg::OP_DEDUP: begin
                            // The first entry is always kept.
                            if (r_count != '0) begin
                                n_k     = CW'(1);
                                n_state = ST_SCAN;
                            end
                        end
                        slc_pkg::OP_READ: begin
                            if (r_count == '0) begin
                                n_res_status = slc_pkg::STATUS_EMPTY;
                            end else if (32'(i_cmd.position) >= 32'(r_count)) begin
                                n_res_status = slc_pkg::STATUS_RANGE;
                            end else begin
                                w_raddr = AW'(i_cmd.position);
                                n_state = ST_RD_WAIT;
                            end
                        end
                        slc_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // Issue the next read of the walk.
                if (r_i != r_count) begin
                    w_raddr = r_i[AW-1:0];
                    n_i     = r_i + CW'(1);
                    n_dv    = 1'b1;
                    n_di    = r_i[AW-1:0];
                end
                // Process the entry read in the previous cycle.
                if (r_dv) begin
                    case (r_op)
                        slc_pkg::OP_DEL_MIN: begin
                            if (r_di == '0 || w_lt) begin
                                n_min = w_rdata;
                                n_idx = r_di;
                            end
                        end
                        slc_pkg::OP_DEL_VAL: begin
                            if (!w_eq) begin
                                w_we = 1'b1;
                                n_k  = r_k + CW'(1);
                            end
                        end
                        slc_pkg::OP_DEDUP: begin
                            if (r_di == '0) begin
                                n_cmp = w_rdata;
                            end else if (!w_eq) begin
                                w_we  = 1'b1;
                                n_cmp = w_rdata;
                                n_k   = r_k + CW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                // The walk ends once every entry has been read and processed.
                if (r_i == r_count && !r_dv) begin
                    if (r_op == slc_pkg::OP_DEL_MIN) begin
                        n_state = ST_FIX_RD;
                    end else begin
                        n_count = r_k;
                        n_state = ST_DONE;
                    end
                end
            end

            ST_FIX_RD: begin
                w_raddr = w_last[AW-1:0];
                n_state = ST_FIX_WR;
            end

            ST_FIX_WR: begin
                // The last entry fills the slot of the minimum.
                w_we        = 1'b1;
                w_waddr     = r_idx;
                n_count     = w_last;
                n_res_value = r_min;
                n_state     = ST_DONE;
            end

            ST_RD_WAIT: begin
                n_res_value = w_rdata;
                n_state     = ST_DONE;
            end

            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_len    = r_count;
                    n_out_status = r_res_status;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_i          <= n_i;
        r_di         <= n_di;
        r_k          <= n_k;
        r_cmp        <= n_cmp;
        r_min        <= n_min;
        r_idx        <= n_idx;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_len    <= n_out_len;
        r_out_status <= n_out_status;
    end

    // The list length never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list length above capacity");

    // Compaction never writes ahead of the entry being processed.
    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && w_we) |-> (r_k <= CW'(r_di)))
        else $error("compaction write ahead of the read walk");

    // An accepted command always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("command accepted but sequencer stayed idle");

    // Any error response carries a zero value.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != slc_pkg::STATUS_OK) |-> (r_out_value == '0))
        else $error("error response with nonzero value");

endmodule

`default_nettype wire

// ===== tb/sequential_list_compactor_core_tb.sv =====
`default_nettype none

module sequential_list_compactor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W        = slc_pkg::VALUE_W;
    localparam int POS_W          = slc_pkg::POS_W;
    localparam int LEN_W          = slc_pkg::LEN_W;
    localparam int LIST_DEPTH     = slc_pkg::DEFAULT_DEPTH;
    localparam int RANDOM_ITEMS   = 450;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLDOFF_AFTER  = 120;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int MAX_REPORTS    = 10;

    // Command codes that the block leaves without effect.
    localparam slc_pkg::t_op OP_SPARE_A = 3'd6;
    localparam slc_pkg::t_op OP_SPARE_B = 3'd7;

    typedef struct packed {
        slc_pkg::t_op              op;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_list_cmd;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [LEN_W-1:0]          list_length;
        slc_pkg::t_status          status;
    } t_list_rsp;

    typedef enum int {SEG_GROW, SEG_SHRINK, SEG_MIXED} t_seg_kind;
    typedef enum int {READY_FREE, READY_PATCHY, READY_SPARSE} t_ready_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    slc_cmd_if cmd_bus ();
    slc_rsp_if rsp_bus ();

    sequential_list_compactor_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the list, updated once per accepted command word.
    logic signed [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
    int                        shadow_count = 0;

    t_list_cmd pending_cmds [$];
    t_list_rsp expected_rsps [$];

    logic                      cmd_taken = 1'b0;
    int                        rsp_words_seen = 0;
    int                        mismatch_count = 0;
    int                        cycle_count = 0;
    logic signed [VALUE_W-1:0] last_appended = '0;

    // Applies one command to the shadow list and returns the response it should produce.
    function automatic t_list_rsp apply_list_command(t_list_cmd cmd);
        t_list_rsp rsp;
        int        min_idx;
        int        keep;
        rsp.result_value = '0;
        rsp.status       = slc_pkg::STATUS_OK;
        case (cmd.op)
            slc_pkg::OP_APPEND: begin
                if (shadow_count >= LIST_DEPTH) begin
                    rsp.status = slc_pkg::STATUS_FULL;
                end else begin
                    shadow_entries[shadow_count] = cmd.value;
                    shadow_count++;
                end
            end
            slc_pkg::OP_DEL_MIN: begin
                if (shadow_count == 0) begin
                    rsp.status = slc_pkg::STATUS_EMPTY;
                end else begin
                    // The first of several equal minima is the one removed.
                    min_idx = 0;
                    for (int i = 1; i < shadow_count; i++) begin
                        if (shadow_entries[i] < shadow_entries[min_idx]) min_idx = i;
                    end
                    rsp.result_value        = shadow_entries[min_idx];
                    shadow_entries[min_idx] = shadow_entries[shadow_count-1];
                    shadow_count--;
                end
            end
            slc_pkg::OP_DEL_VAL: begin
                keep = 0;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_entries[i] != cmd.value) begin
                        shadow_entries[keep] = shadow_entries[i];
                        keep++;
                    end
                end
                shadow_count = keep;
            end
            slc_pkg::OP_DEDUP: begin
                if (shadow_count > 0) begin
                    keep = 1;
                    for (int i = 1; i < shadow_count; i++) begin
                        if (shadow_entries[i] != shadow_entries[keep-1]) begin
                            shadow_entries[keep] = shadow_entries[i];
                            keep++;
                        end
                    end
                    shadow_count = keep;
                end
            end
            slc_pkg::OP_READ: begin
                if (shadow_count == 0) begin
                    rsp.status = slc_pkg::STATUS_EMPTY;
                end else if (int'(cmd.position) >= shadow_count) begin
                    rsp.status = slc_pkg::STATUS_RANGE;
                end else begin
                    rsp.result_value = shadow_entries[cmd.position];
                end
            end
            slc_pkg::OP_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        rsp.list_length = LEN_W'(shadow_count);
        return rsp;
    endfunction

    function automatic t_list_cmd make_cmd(slc_pkg::t_op op,
                                           logic signed [VALUE_W-1:0] value,
                                           logic [POS_W-1:0] position);
        t_list_cmd cmd;
        cmd.op       = op;
        cmd.value    = value;
        cmd.position = position;
        return cmd;
    endfunction

    // Mostly a small pool so that removals and repeats hit, sometimes extremes or any pattern.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return VALUE_W'(int'($urandom_range(0, 9)) - 5);
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: return {1'b1, {(VALUE_W-1){1'b0}}};
                1: return {1'b0, {(VALUE_W-1){1'b1}}};
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 1) == 0) return POS_W'($urandom_range(0, 15));
        return POS_W'($urandom);
    endfunction

    // One random command whose operation mix depends on the kind of segment.
    function automatic t_list_cmd random_command(t_seg_kind kind);
        int                        r;
        slc_pkg::t_op              op;
        logic signed [VALUE_W-1:0] value;
        r     = $urandom_range(0, 99);
        value = pick_value();
        case (kind)
            SEG_GROW: begin
                if (r < 80) op = slc_pkg::OP_APPEND;
                else if (r < 90) op = slc_pkg::OP_READ;
                else if (r < 95) op = slc_pkg::OP_DEDUP;
                else op = slc_pkg::OP_DEL_VAL;
            end
            SEG_SHRINK: begin
                if (r < 35) op = slc_pkg::OP_DEL_MIN;
                else if (r < 55) op = slc_pkg::OP_DEL_VAL;
                else if (r < 70) op = slc_pkg::OP_DEDUP;
                else if (r < 85) op = slc_pkg::OP_READ;
                else if (r < 97) op = slc_pkg::OP_APPEND;
                else op = slc_pkg::OP_CLEAR;
            end
            default: begin
                if (r < 2) op = ($urandom_range(0, 1) == 0) ? OP_SPARE_A : OP_SPARE_B;
                else if (r < 8) op = slc_pkg::OP_CLEAR;
                else op = slc_pkg::t_op'($urandom_range(0, 4));
            end
        endcase
        // Repeat the previous appended value now and then to build adjacent runs.
        if (op == slc_pkg::OP_APPEND) begin
            if ($urandom_range(0, 9) < 4) value = last_appended;
            last_appended = value;
        end
        return make_cmd(op, value, pick_position());
    endfunction

    task automatic report_mismatch(string what, t_list_rsp want, t_list_rsp got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch (%s): expected value=%0d len=%0d status=%0d,",
                     $realtime, what, want.result_value, want.list_length, want.status);
            $display("    got value=%0d len=%0d status=%0d",
                     got.result_value, got.list_length, got.status);
        end
    endtask

    // Monitor: predict on every accepted command word, check every accepted response word.
    always @(posedge i_clk) begin
        t_list_rsp got;
        t_list_rsp want;
        cmd_taken <= i_rst_n && cmd_bus.valid && cmd_bus.ready;
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            expected_rsps.push_back(apply_list_command(
                make_cmd(cmd_bus.op, cmd_bus.value, cmd_bus.position)));
        end
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            rsp_words_seen++;
            got.result_value = rsp_bus.result_value;
            got.list_length  = rsp_bus.list_length;
            got.status       = rsp_bus.status;
            if (expected_rsps.size() == 0) begin
                report_mismatch("response with nothing outstanding", '0, got);
            end else begin
                want = expected_rsps.pop_front();
                if (got.result_value !== want.result_value)
                    report_mismatch("result_value", want, got);
                if (got.list_length !== want.list_length)
                    report_mismatch("list_length", want, got);
                if (got.status !== want.status)
                    report_mismatch("status", want, got);
            end
        end
    end

    // Driver: sends queued command words in bursts separated by random gaps.
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        t_list_cmd next_cmd;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else if (cmd_bus.valid && !cmd_taken) begin
            // Hold the current word until it is taken.
        end else if (gap_left > 0) begin
            cmd_bus.valid <= 1'b0;
            gap_left--;
        end else if (pending_cmds.size() > 0) begin
            next_cmd          = pending_cmds.pop_front();
            cmd_bus.valid    <= 1'b1;
            cmd_bus.op       <= next_cmd.op;
            cmd_bus.value    <= next_cmd.value;
            cmd_bus.position <= next_cmd.position;
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 30);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end else begin
            cmd_bus.valid <= 1'b0;
        end
    end

    // Receiver: ready follows changing stall patterns, with one long hold-off to back up the input.
    t_ready_mode ready_mode      = READY_FREE;
    int          ready_phase     = 0;
    int          holdoff_left    = 0;
    logic        holdoff_done    = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_bus.ready <= 1'b0;
        end else if (!holdoff_done && rsp_words_seen >= HOLDOFF_AFTER) begin
            holdoff_done  = 1'b1;
            holdoff_left  = HOLDOFF_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
        end else begin
            if (ready_phase == 0) begin
                ready_mode  = t_ready_mode'($urandom_range(0, 2));
                ready_phase = $urandom_range(20, 120);
            end
            ready_phase--;
            case (ready_mode)
                READY_FREE:   rsp_bus.ready <= 1'b1;
                READY_PATCHY: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                default:      rsp_bus.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int        queued;
        int        seg_len;
        t_seg_kind kind;
        int        r;

        i_rst_n          = 1'b0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.op       = slc_pkg::OP_APPEND;
        cmd_bus.value    = '0;
        cmd_bus.position = '0;
        rsp_bus.ready    = 1'b0;

        // Directed part: empty-list commands, spare codes, extreme values, range errors.
        pending_cmds.push_back(make_cmd(slc_pkg::OP_DEL_MIN, '0, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_READ, '0, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_DEL_VAL, '0, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_DEDUP, '0, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_CLEAR, '0, '0));
        pending_cmds.push_back(make_cmd(OP_SPARE_A, '1, '1));
        pending_cmds.push_back(make_cmd(OP_SPARE_B, '0, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_APPEND, {1'b1, {(VALUE_W-1){1'b0}}}, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_APPEND, {1'b0, {(VALUE_W-1){1'b1}}}, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_APPEND, {1'b0, {(VALUE_W-1){1'b1}}}, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_APPEND, '1, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_APPEND, '0, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_APPEND, {1'b1, {(VALUE_W-1){1'b0}}}, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_APPEND, '1, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_READ, '0, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_READ, '0, POS_W'(6)));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_READ, '0, POS_W'(7)));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_READ, '0, '1));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_DEDUP, '0, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_DEL_VAL, {1'b1, {(VALUE_W-1){1'b0}}}, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_DEL_MIN, '0, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_DEL_MIN, '0, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_CLEAR, '0, '0));
        pending_cmds.push_back(make_cmd(slc_pkg::OP_READ, '0, '0));

        // Random part in segments; the first one is a growing segment of mostly appends.
        queued  = 0;
        kind    = SEG_GROW;
        seg_len = 80;
        while (queued < RANDOM_ITEMS) begin
            for (int i = 0; i < seg_len; i++) begin
                pending_cmds.push_back(random_command(kind));
            end
            queued += seg_len;
            r = $urandom_range(0, 9);
            kind    = (r < 4) ? SEG_GROW : (r < 7) ? SEG_SHRINK : SEG_MIXED;
            seg_len = $urandom_range(15, 60);
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Let everything be sent, then drain the responses and allow for the longest command.
        while (pending_cmds.size() != 0 || cmd_bus.valid) @(posedge i_clk);
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/slc_pkg.sv
src/slc_if.sv
src/slc_ram.sv
src/sequential_list_compactor_core.sv
tb/sequential_list_compactor_core_tb.sv
